// ----- src/rbi_pkg.sv -----
// Shared constants, request and result types for the repetition block interleaver.
package rbi_pkg;

  // Bit store geometry.
  localparam int STORE_DEPTH = 8192;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int PROD_W      = CNT_W + 2;

  // Matrix shapes for the two supported repetition factors.
  localparam int STRONG_ROWS = 144;
  localparam int STRONG_COLS = 91;
  localparam int STRONG_REP  = 3;
  localparam int WEAK_ROWS   = 104;
  localparam int WEAK_COLS   = 84;
  localparam int WEAK_REP    = 2;

  localparam int STRONG_CELLS = STRONG_ROWS * STRONG_COLS;
  localparam int WEAK_CELLS   = WEAK_ROWS * WEAK_COLS;

  // Stepping one row down adds cols to the flat position; split by the factor.
  localparam int STRONG_STEP_Q = STRONG_COLS / STRONG_REP;
  localparam int STRONG_STEP_R = STRONG_COLS % STRONG_REP;
  localparam int WEAK_STEP_Q   = WEAK_COLS / WEAK_REP;
  localparam int WEAK_STEP_R   = WEAK_COLS % WEAK_REP;

  localparam int ROW_W = 8;
  localparam int COL_W = 7;
  localparam int REM_W = 2;

  // Repetition factor codes.
  localparam logic [1:0] FACTOR_STRONG = 2'd3;
  localparam logic [1:0] FACTOR_WEAK   = 2'd2;

  // Request kinds.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  // Queue depths.
  localparam int OPQ_DEPTH = 4;
  localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNSUP     = 2'd1,
    ST_SHORT     = 2'd2,
    ST_NOT_READY = 2'd3
  } status_t;

  typedef struct packed {
    logic req_type;
    logic bit_in;
    logic last_in;
  } item_t;

  typedef struct packed {
    logic    bit_out;
    logic    last_out;
    status_t status;
  } result_t;

  // One classified request handed from the front to the back.
  typedef struct packed {
    logic              we;
    logic              wbit;
    logic              rd;
    logic              emit;
    logic              last;
    status_t           status;
    logic [ADDR_W-1:0] addr;
  } op_t;

endpackage

// ----- src/repetition_block_interleaver_core.sv -----
// Top level of the repetition and row-column block interleaver.
//
// Requests enter through a queue-style port: a request is taken when push is
// high and full is low. A load stores one coded bit if the store has room;
// the load marked last closes the frame and yields one result with the frame
// status. A fetch request yields the next bit of the column-by-column readout,
// or a not-ready status when no good frame is held. Other loads yield nothing.
// Results leave through a queue-style port: the oldest result sits on result
// while empty is low and is taken when pop is high.
// The user must write the repetition factor on the cfg channel (cfg_ready is
// always high) only while the block is idle; the block does not enforce it.
// The factor resets to 3. A request is taken every cycle while the internal
// queues have room. One bit store port serves one load or one fetch per cycle,
// which sets the rate at one request a cycle. When the receiver stops popping,
// the four-entry result queue fills, the four-entry operation queue behind it
// fills, and then full rises. Reset empties both queues, clears the frame and
// sets the factor to 3; the bit store keeps its contents, needing no clearing.
module repetition_block_interleaver_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  rbi_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output rbi_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_data
);

  logic         op_push, op_pop, op_empty, q_full;
  rbi_pkg::op_t op_in, op_head;

  assign cfg_ready = 1'b1;
  assign full      = q_full;

  // Request classification and frame bookkeeping.
  rbi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .q_full    (q_full),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .op_push   (op_push),
    .op        (op_in)
  );

  // Decoupling queue.
  rbi_op_queue u_op_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (op_push),
    .din   (op_in),
    .full  (q_full),
    .pop   (op_pop),
    .empty (op_empty),
    .head  (op_head)
  );

  // Bit store and result delivery.
  rbi_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_empty (op_empty),
    .op       (op_head),
    .op_pop   (op_pop),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

  // The block comes out of reset with nothing pending and room for requests.
  a_reset_clean : assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // Only a good fetch can mark the end of the readout.
  a_last_ok : assert property (@(posedge clk) disable iff (rst)
    !empty && result.last_out |-> result.status == rbi_pkg::ST_OK)
    else $error("last_out with a failing status");

  // Failing results never carry data.
  a_bad_no_bit : assert property (@(posedge clk) disable iff (rst)
    !empty && result.status != rbi_pkg::ST_OK |-> !result.bit_out)
    else $error("bit_out set on a failing status");

  // An operation only leaves the queue when one is there.
  a_pop_guard : assert property (@(posedge clk) disable iff (rst)
    op_pop |-> !op_empty)
    else $error("operation queue popped while empty");

endmodule

// ----- src/rbi_front.sv -----
// Front end: accepts requests, tracks frame and read position, emits store operations.
module rbi_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rbi_pkg::item_t item,
  input  logic          q_full,
  input  logic          cfg_valid,
  input  logic [1:0]    cfg_data,
  output logic          op_push,
  output rbi_pkg::op_t  op
);

  logic [1:0]                   factor;
  logic [rbi_pkg::CNT_W-1:0]    received_count, received_count_next;
  logic                         frame_ready, frame_ready_next;
  logic                         geom_strong, geom_strong_next;
  logic [rbi_pkg::ROW_W-1:0]    read_row, read_row_next;
  logic [rbi_pkg::COL_W-1:0]    read_column, read_column_next;
  logic [rbi_pkg::ADDR_W-1:0]   cur_q, cur_q_next, col_q, col_q_next;
  logic [rbi_pkg::REM_W-1:0]    cur_m, cur_m_next, col_m, col_m_next;

  logic                         accept;
  logic [rbi_pkg::CNT_W-1:0]    cnt_base, cnt_new;
  logic                         store_ok;
  logic [rbi_pkg::PROD_W-1:0]   need, have;
  logic [rbi_pkg::ROW_W-1:0]    rows_last;
  logic [rbi_pkg::COL_W-1:0]    cols_last;
  logic [rbi_pkg::REM_W-1:0]    rep, step_r;
  logic [rbi_pkg::ADDR_W-1:0]   step_q;
  logic [rbi_pkg::REM_W:0]      m_sum;

  assign accept = push && !q_full;

  // Geometry of the frame currently held.
  always_comb begin
    if (geom_strong) begin
      rows_last = rbi_pkg::ROW_W'(rbi_pkg::STRONG_ROWS - 1);
      cols_last = rbi_pkg::COL_W'(rbi_pkg::STRONG_COLS - 1);
      rep       = rbi_pkg::REM_W'(rbi_pkg::STRONG_REP);
      step_q    = rbi_pkg::ADDR_W'(rbi_pkg::STRONG_STEP_Q);
      step_r    = rbi_pkg::REM_W'(rbi_pkg::STRONG_STEP_R);
    end else begin
      rows_last = rbi_pkg::ROW_W'(rbi_pkg::WEAK_ROWS - 1);
      cols_last = rbi_pkg::COL_W'(rbi_pkg::WEAK_COLS - 1);
      rep       = rbi_pkg::REM_W'(rbi_pkg::WEAK_REP);
      step_q    = rbi_pkg::ADDR_W'(rbi_pkg::WEAK_STEP_Q);
      step_r    = rbi_pkg::REM_W'(rbi_pkg::WEAK_STEP_R);
    end
  end

  // Load bookkeeping: where the bit goes and how long the frame is.
  assign cnt_base = frame_ready ? '0 : received_count;
  assign store_ok = cnt_base < rbi_pkg::CNT_W'(rbi_pkg::STORE_DEPTH);
  assign cnt_new  = cnt_base + rbi_pkg::CNT_W'(store_ok);
  assign need     = (factor == rbi_pkg::FACTOR_STRONG) ?
                    rbi_pkg::PROD_W'(rbi_pkg::STRONG_CELLS) :
                    rbi_pkg::PROD_W'(rbi_pkg::WEAK_CELLS);
  assign have     = rbi_pkg::PROD_W'(cnt_new) * rbi_pkg::PROD_W'(factor);
  assign m_sum    = {1'b0, cur_m} + {1'b0, step_r};

  // Classify the request and advance the frame state.
  always_comb begin
    received_count_next = received_count;
    frame_ready_next    = frame_ready;
    geom_strong_next    = geom_strong;
    read_row_next       = read_row;
    read_column_next    = read_column;
    cur_q_next          = cur_q;
    cur_m_next          = cur_m;
    col_q_next          = col_q;
    col_m_next          = col_m;
    op                  = '0;
    op.status           = rbi_pkg::ST_OK;
    op_push             = accept;
    if (accept) begin
      if (item.req_type == rbi_pkg::REQ_LOAD) begin
        frame_ready_next    = 1'b0;
        op.we               = store_ok;
        op.wbit             = item.bit_in;
        op.addr             = cnt_base[rbi_pkg::ADDR_W-1:0];
        received_count_next = cnt_new;
        if (item.last_in) begin
          received_count_next = '0;
          op.emit             = 1'b1;
          if (factor != rbi_pkg::FACTOR_STRONG && factor != rbi_pkg::FACTOR_WEAK) begin
            op.status = rbi_pkg::ST_UNSUP;
          end else if (have < need) begin
            op.status = rbi_pkg::ST_SHORT;
          end else begin
            frame_ready_next = 1'b1;
            geom_strong_next = (factor == rbi_pkg::FACTOR_STRONG);
            read_row_next    = '0;
            read_column_next = '0;
            cur_q_next       = '0;
            cur_m_next       = '0;
            col_q_next       = '0;
            col_m_next       = '0;
          end
        end
      end else begin
        op.emit = 1'b1;
        if (!frame_ready) begin
          op.status = rbi_pkg::ST_NOT_READY;
        end else begin
          op.rd   = 1'b1;
          op.addr = cur_q;
          if (read_row == rows_last) begin
            read_row_next = '0;
            if (read_column == cols_last) begin
              read_column_next = '0;
              frame_ready_next = 1'b0;
              op.last          = 1'b1;
            end else begin
              // Next column starts at flat position column+1.
              read_column_next = read_column + 1'b1;
              if (col_m == rep - 1'b1) begin
                col_m_next = '0;
                col_q_next = col_q + 1'b1;
                cur_m_next = '0;
                cur_q_next = col_q + 1'b1;
              end else begin
                col_m_next = col_m + 1'b1;
                cur_m_next = col_m + 1'b1;
                cur_q_next = col_q;
              end
            end
          end else begin
            // One row down adds cols to the flat position.
            read_row_next = read_row + 1'b1;
            if (m_sum >= {1'b0, rep}) begin
              cur_m_next = rbi_pkg::REM_W'(m_sum - {1'b0, rep});
              cur_q_next = cur_q + step_q + 1'b1;
            end else begin
              cur_m_next = m_sum[rbi_pkg::REM_W-1:0];
              cur_q_next = cur_q + step_q;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      factor         <= rbi_pkg::FACTOR_STRONG;
      received_count <= '0;
      frame_ready    <= 1'b0;
      geom_strong    <= 1'b1;
      read_row       <= '0;
      read_column    <= '0;
      cur_q          <= '0;
      cur_m          <= '0;
      col_q          <= '0;
      col_m          <= '0;
    end else begin
      if (cfg_valid) begin
        factor <= cfg_data;
      end
      received_count <= received_count_next;
      frame_ready    <= frame_ready_next;
      geom_strong    <= geom_strong_next;
      read_row       <= read_row_next;
      read_column    <= read_column_next;
      cur_q          <= cur_q_next;
      cur_m          <= cur_m_next;
      col_q          <= col_q_next;
      col_m          <= col_m_next;
    end
  end

endmodule

// ----- src/rbi_op_queue.sv -----
// Short queue of classified operations between the front and the back.
module rbi_op_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  rbi_pkg::op_t din,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output rbi_pkg::op_t head
);

  rbi_pkg::op_t                  entries [rbi_pkg::OPQ_DEPTH];
  logic [rbi_pkg::OPQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [rbi_pkg::OPQ_PTR_W:0]   count;
  logic                          do_push, do_pop;

  assign full    = count == (rbi_pkg::OPQ_PTR_W + 1)'(rbi_pkg::OPQ_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (rbi_pkg::OPQ_PTR_W + 1)'(do_push) - (rbi_pkg::OPQ_PTR_W + 1)'(do_pop);
    end
  end

endmodule

// ----- src/rbi_back.sv -----
// Back end: bit store accesses and the result queue toward the receiver.
module rbi_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            op_empty,
  input  rbi_pkg::op_t    op,
  output logic            op_pop,
  output logic            empty,
  input  logic            pop,
  output rbi_pkg::result_t result
);

  logic                            mem [rbi_pkg::STORE_DEPTH];
  logic                            rdata;
  logic                            s1_emit, s1_rd, s1_last;
  rbi_pkg::status_t                s1_status;
  rbi_pkg::result_t                out_q [rbi_pkg::OUT_DEPTH];
  logic [rbi_pkg::OUT_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [rbi_pkg::OUT_PTR_W:0]     count;
  logic [rbi_pkg::OUT_PTR_W+1:0]   committed;
  rbi_pkg::result_t                s1_result;
  logic                            take, do_pop;

  // Take an operation only when its result is sure to find room.
  assign committed = (rbi_pkg::OUT_PTR_W + 2)'(count) + (rbi_pkg::OUT_PTR_W + 2)'(s1_emit);
  assign take      = !op_empty && (committed < (rbi_pkg::OUT_PTR_W + 2)'(rbi_pkg::OUT_DEPTH));
  assign op_pop    = take;

  // Bit store: one write or one registered read per operation.
  always_ff @(posedge clk) begin
    if (take && op.we) begin
      mem[op.addr] <= op.wbit;
    end
    if (take && op.rd) begin
      rdata <= mem[op.addr];
    end
  end

  // Result stage aligned with the store read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_emit <= 1'b0;
    end else begin
      s1_emit <= take && op.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_rd     <= op.rd;
      s1_last   <= op.last;
      s1_status <= op.status;
    end
  end

  always_comb begin
    s1_result.bit_out  = s1_rd ? rdata : 1'b0;
    s1_result.last_out = s1_last;
    s1_result.status   = s1_status;
  end

  // Result queue toward the receiver.
  assign empty  = count == '0;
  assign do_pop = pop && !empty;
  assign result = out_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (s1_emit) begin
      out_q[wr_ptr] <= s1_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (s1_emit) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (rbi_pkg::OUT_PTR_W + 1)'(s1_emit) - (rbi_pkg::OUT_PTR_W + 1)'(do_pop);
    end
  end

endmodule

// ----- tb/sv/repetition_block_interleaver_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the repetition and row-column block interleaver core.
module repetition_block_interleaver_core_tb;
  import rbi_pkg::*;

  // Worst case is near 53k requests and 24k results.
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          SHORT_TARGET  = 900;
  localparam int          PRINT_CAP     = 40;
  localparam int          STRONG_FRAME  = STRONG_CELLS / STRONG_REP;
  localparam int          WEAK_FRAME    = WEAK_CELLS / WEAK_REP;

  // Factor codes that the block rejects.
  localparam logic [1:0] FACTOR_NONE = 2'd0;
  localparam logic [1:0] FACTOR_ONE  = 2'd1;

  localparam result_t NO_RES = '{1'b0, 1'b0, ST_OK};

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef enum int {
    SCN_STRONG_FULL,
    SCN_WEAK_SWITCH,
    SCN_STRONG_CUT,
    SCN_OVERFLOW
  } scenario_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [1:0] factor;
    item_t      req;
    logic       typed;
    result_t    want;
  } stim_row_t;

  localparam int N_ROWS = 17;

  // Directed rows; typed results are the obvious status codes, the rest use the predictor.
  stim_row_t stim_rows [N_ROWS] = '{
    '{ROW_REQ, 2'd0, '{REQ_FETCH, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, ST_NOT_READY}},
    '{ROW_REQ, 2'd0, '{REQ_LOAD, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, ST_SHORT}},
    '{ROW_REQ, 2'd0, '{REQ_LOAD, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{ROW_REQ, 2'd0, '{REQ_LOAD, 1'b1, 1'b0}, 1'b0, NO_RES},
    '{ROW_REQ, 2'd0, '{REQ_LOAD, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, ST_SHORT}},
    '{ROW_CFG, FACTOR_NONE, '{REQ_LOAD, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{ROW_REQ, 2'd0, '{REQ_LOAD, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, ST_UNSUP}},
    '{ROW_REQ, 2'd0, '{REQ_FETCH, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, ST_NOT_READY}},
    '{ROW_CFG, FACTOR_ONE, '{REQ_LOAD, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{ROW_REQ, 2'd0, '{REQ_LOAD, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{ROW_REQ, 2'd0, '{REQ_LOAD, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, ST_UNSUP}},
    '{ROW_CFG, FACTOR_WEAK, '{REQ_LOAD, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{ROW_REQ, 2'd0, '{REQ_LOAD, 1'b0, 1'b1}, 1'b1, '{1'b0, 1'b0, ST_SHORT}},
    '{ROW_REQ, 2'd0, '{REQ_FETCH, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, ST_NOT_READY}},
    '{ROW_CFG, FACTOR_STRONG, '{REQ_LOAD, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{ROW_REQ, 2'd0, '{REQ_FETCH, 1'b0, 1'b1}, 1'b1, '{1'b0, 1'b0, ST_NOT_READY}},
    '{ROW_REQ, 2'd0, '{REQ_LOAD, 1'b0, 1'b1}, 1'b1, '{1'b0, 1'b0, ST_SHORT}}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  item_t      item = '0;
  logic       empty;
  logic       pop = 1'b0;
  result_t    result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data = 2'd0;

  // Typed result that travels alongside the request being offered.
  logic       chk_typed = 1'b0;
  result_t    chk_value = '0;

  // Predictor state: the held frame, its read position and the factor.
  bit          coded_bits [STORE_DEPTH];
  int unsigned coded_len = 0;
  bit          held = 1'b0;
  int unsigned row_at = 0;
  int unsigned col_at = 0;
  bit          held_strong = 1'b1;
  logic [1:0]  factor_now = FACTOR_STRONG;

  result_t     pending_results [$];
  int          bad_count = 0;
  int unsigned popped = 0;
  int unsigned cycles = 0;
  bit          tx_idle = 1'b1;

  repetition_block_interleaver_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Computes the result of one accepted request and advances the frame state.
  function automatic bit predict_request(input item_t r, output result_t res);
    int unsigned rows;
    int unsigned cols;
    int unsigned rep;
    res = NO_RES;
    if (r.req_type == REQ_LOAD) begin
      if (held) begin
        held = 1'b0;
        row_at = 0;
        col_at = 0;
        coded_len = 0;
      end
      if (coded_len < STORE_DEPTH) begin
        coded_bits[coded_len] = r.bit_in;
        coded_len++;
      end
      if (!r.last_in) return 1'b0;
      if (factor_now == FACTOR_STRONG) begin
        rows = STRONG_ROWS;
        cols = STRONG_COLS;
      end else if (factor_now == FACTOR_WEAK) begin
        rows = WEAK_ROWS;
        cols = WEAK_COLS;
      end else begin
        coded_len = 0;
        res.status = ST_UNSUP;
        return 1'b1;
      end
      rep = factor_now;
      if (coded_len * rep < rows * cols) begin
        coded_len = 0;
        res.status = ST_SHORT;
        return 1'b1;
      end
      coded_len = 0;
      held = 1'b1;
      held_strong = (factor_now == FACTOR_STRONG);
      row_at = 0;
      col_at = 0;
      return 1'b1;
    end
    if (!held) begin
      res.status = ST_NOT_READY;
      return 1'b1;
    end
    // Column-major readout; the geometry is the one latched with the frame.
    rows = held_strong ? STRONG_ROWS : WEAK_ROWS;
    cols = held_strong ? STRONG_COLS : WEAK_COLS;
    rep  = held_strong ? STRONG_REP : WEAK_REP;
    res.bit_out = coded_bits[(row_at * cols + col_at) / rep];
    row_at++;
    if (row_at >= rows) begin
      row_at = 0;
      col_at++;
      if (col_at >= cols) begin
        col_at = 0;
        held = 1'b0;
        res.last_out = 1'b1;
      end
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    bad_count++;
    if (bad_count <= PRINT_CAP)
      $display("mismatch on result %0d: %s got %0d, wanted %0d", popped, what, got_v, want_v);
  endtask

  // Watches both handshakes at each edge: predicts accepted requests, checks popped results.
  always @(posedge clk) begin : watch
    result_t pred;
    result_t want;
    if (!rst) begin
      if (push && !full) begin
        if (predict_request(item, pred))
          pending_results.push_back(chk_typed ? chk_value : pred);
      end
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unrequested status", int'(result.status), -1);
        end else begin
          want = pending_results.pop_front();
          if (result.bit_out !== want.bit_out)
            report_mismatch("bit_out", int'(result.bit_out), int'(want.bit_out));
          if (result.last_out !== want.last_out)
            report_mismatch("last_out", int'(result.last_out), int'(want.last_out));
          if (result.status !== want.status)
            report_mismatch("status", int'(result.status), int'(want.status));
        end
        popped++;
      end
    end
  end

  // Run limit.
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[repetition_block_interleaver_core] ERROR");
    $finish;
  end

  // Result side: random stalls before each pop, in stretches with and without them.
  initial begin : drain_side
    int gap;
    bit rx_idle;
    int unsigned served;
    rx_idle = 1'b1;
    served = 0;
    wait (rst == 1'b0);
    forever begin
      if (served % 64 == 0) rx_idle = ($urandom_range(0, 3) != 0);
      gap = rx_idle ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      served++;
    end
  end

  // Offers one request after a random gap and returns at the edge that takes it.
  task automatic send_req(input item_t r, input logic typed, input result_t typed_val);
    int gap;
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    item      <= r;
    chk_typed <= typed;
    chk_value <= typed_val;
    do @(posedge clk); while (full !== 1'b0);
  endtask

  task automatic load_one(input logic b, input logic last);
    item_t r;
    r.req_type = REQ_LOAD;
    r.bit_in   = b;
    r.last_in  = last;
    send_req(r, 1'b0, NO_RES);
  endtask

  task automatic fetch_one();
    item_t r;
    r.req_type = REQ_FETCH;
    r.bit_in   = 1'($urandom_range(0, 1));
    r.last_in  = 1'($urandom_range(0, 1));
    send_req(r, 1'b0, NO_RES);
  endtask

  // A frame of n random coded bits, the last one marked.
  task automatic load_run(input int unsigned n);
    for (int unsigned k = 0; k < n; k++) load_one(1'($urandom_range(0, 1)), k == n - 1);
  endtask

  task automatic fetch_run(input int unsigned n);
    repeat (n) fetch_one();
  endtask

  // Stops offering, waits for every pending result, then lets trailing loads finish.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_factor(input logic [1:0] f);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= f;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    factor_now = f;
  endtask

  // Full-size frames: good readouts, short boundaries, factor change and overflow.
  task automatic big_frame(input scenario_t kind);
    int unsigned part;
    tx_idle = ($urandom_range(0, 1) != 0);
    case (kind)
      SCN_STRONG_FULL: begin
        // A few surplus bits beyond the matrix are ignored; one fetch past the end.
        write_factor(FACTOR_STRONG);
        load_run(STRONG_FRAME + $urandom_range(0, 5));
        fetch_run(STRONG_CELLS + 1);
      end
      SCN_WEAK_SWITCH: begin
        // One bit short first, then a good frame read across a factor change.
        write_factor(FACTOR_WEAK);
        load_run(WEAK_FRAME - 1);
        load_run(WEAK_FRAME);
        part = $urandom_range(1, WEAK_CELLS - 1);
        fetch_run(part);
        write_factor(FACTOR_NONE);
        fetch_run(WEAK_CELLS - part + 1);
      end
      SCN_STRONG_CUT: begin
        // A readout cut off by a new frame, which discards the held one.
        write_factor(FACTOR_STRONG);
        load_run(STRONG_FRAME - 1);
        load_run(STRONG_FRAME);
        fetch_run($urandom_range(1, 500));
        load_run(3);
        fetch_one();
      end
      default: begin
        // Loads past the store size are dropped, yet the last mark still closes.
        write_factor(FACTOR_WEAK);
        load_run(STORE_DEPTH + $urandom_range(1, 8));
        fetch_run($urandom_range(1, 300));
      end
    endcase
  endtask

  initial begin : main_seq
    int unsigned short_items;
    int unsigned big_done;
    int unsigned n;
    int unsigned pick;
    item_t r;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed rows.
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) write_factor(stim_rows[i].factor);
      else send_req(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].want);
    end

    // Random episodes, with the full-size frames spread among them.
    short_items = 0;
    big_done = 0;
    while (short_items < SHORT_TARGET) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        // Short frame, sometimes under a new factor, with stray fetches mixed in.
        if ($urandom_range(0, 2) == 0) write_factor(2'($urandom_range(0, 3)));
        n = $urandom_range(1, 24);
        for (int unsigned k = 0; k < n; k++) begin
          if ($urandom_range(0, 5) == 0) begin
            fetch_one();
            short_items++;
          end
          load_one(1'($urandom_range(0, 1)), k == n - 1);
        end
        short_items += n;
      end else begin
        // Noise: any mix of requests, with an occasional last mark.
        n = $urandom_range(1, 16);
        repeat (n) begin
          r.req_type = 1'($urandom_range(0, 1));
          r.bit_in   = 1'($urandom_range(0, 1));
          r.last_in  = ($urandom_range(0, 7) == 0);
          send_req(r, 1'b0, NO_RES);
        end
        short_items += n;
      end
      if (big_done < 4 && short_items >= (big_done + 1) * 200) begin
        big_frame(scenario_t'(big_done));
        big_done++;
      end
    end

    settle();
    if (bad_count == 0) $display("[repetition_block_interleaver_core] OK");
    else $display("[repetition_block_interleaver_core] ERROR");
    $finish;
  end

endmodule
